>>> hw/rtl/css_pkg.sv
`default_nettype none

package css_pkg;

    localparam int STACK_SLOTS  = 64;
    localparam int RANDOM_BITS  = 15;
    localparam int DECK_CARDS   = 52;
    localparam int SUIT_COUNT   = 4;
    localparam int NUMBER_COUNT = 13;

    localparam int CARD_W      = 6;
    localparam int SUIT_W      = $clog2(SUIT_COUNT);
    localparam int NUM_W       = CARD_W - SUIT_W;
    localparam int KIND_W      = 2;
    localparam int RAND_IN_W   = 15;
    localparam int COUNT_OUT_W = 7;
    localparam int ADDR_W      = $clog2(STACK_SLOTS);
    localparam int COUNT_W     = $clog2(STACK_SLOTS + 1);
    localparam int DIV_W       = RANDOM_BITS + 1;
    localparam int STEP_W      = $clog2(RANDOM_BITS + 1);

    localparam logic [RANDOM_BITS-1:0] RANDOM_FULL_SCALE = '1;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SHUFFLE = 2'd3;

    typedef struct packed {
        logic                   start;
        logic [RANDOM_BITS-1:0] dividend;
        logic [DIV_W-1:0]       divisor;
    } css_div_req_t;

    typedef struct packed {
        logic                   done;
        logic [RANDOM_BITS-1:0] quotient;
    } css_div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/css_if.sv
`default_nettype none

interface css_req_if
    import css_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CARD_W-1:0]    card_in;
    logic [RAND_IN_W-1:0] random_word;

    modport source (output valid, output kind, output card_in, output random_word, input ready);
    modport sink   (input valid, input kind, input card_in, input random_word, output ready);
endinterface

interface css_rsp_if
    import css_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CARD_W-1:0]      card_out;
    logic                   failed;
    logic                   is_empty;
    logic [COUNT_OUT_W-1:0] count_out;
    logic                   shuffle_done;

    modport source (output valid, output card_out, output failed, output is_empty,
                    output count_out, output shuffle_done, input ready);
    modport sink   (input valid, input card_out, input failed, input is_empty,
                    input count_out, input shuffle_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/css_ram.sv
`default_nettype none

module css_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/css_div.sv
`default_nettype none

module css_div
    import css_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire css_div_req_t req,
    output css_div_rsp_t      rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [RANDOM_BITS-1:0] quot_reg, quot_next;
    logic [DIV_W:0]         trial;
    logic                   fits;

    assign trial = {rem_reg, quot_reg[RANDOM_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RANDOM_BITS);
            rem_next  = '0;
            quot_next = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DIV_W'(trial - {1'b0, div_reg}) : DIV_W'(trial);
            quot_next = {quot_reg[RANDOM_BITS-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign rsp = '{done: done_reg, quotient: quot_reg};

endmodule

`default_nettype wire

>>> hw/rtl/card_stack_shuffler_core.sv
// Work per transaction: a push passes the execute state, a pop or peek on a nonempty stack
// also waits for the memory read, and a shuffle step makes two passes through the shared
// restoring divider at one quotient bit per cycle, then swaps two cards in the memory.
// One transaction is in work at a time; the next is taken in the cycle after the result is
// handed to the output register. After reset the card memory is loaded in build order by a
// sweep over all 64 slots, one entry per cycle; no transaction is accepted until it ends.
`default_nettype none

module card_stack_shuffler_core
    import css_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    css_req_if.sink     req,
    css_rsp_if.source   rsp
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_RD_WAIT = 4'd3;
    localparam logic [3:0] S_DIV1    = 4'd4;
    localparam logic [3:0] S_DIV2    = 4'd5;
    localparam logic [3:0] S_RD_I    = 4'd6;
    localparam logic [3:0] S_RD_J    = 4'd7;
    localparam logic [3:0] S_WR_I    = 4'd8;
    localparam logic [3:0] S_WR_J    = 4'd9;
    localparam logic [3:0] S_RESULT  = 4'd10;

    logic [3:0]             state_reg, state_next;
    logic [ADDR_W-1:0]      init_idx_reg, init_idx_next;
    logic [SUIT_W-1:0]      init_suit_reg, init_suit_next;
    logic [NUM_W-1:0]       init_num_reg, init_num_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]      cursor_reg, cursor_next;

    logic [KIND_W-1:0]      kind_reg;
    logic [CARD_W-1:0]      card_reg;
    logic [RANDOM_BITS-1:0] rand_reg;
    logic [ADDR_W-1:0]      j_reg, j_next;
    logic [CARD_W-1:0]      tmp_reg, tmp_next;
    logic [CARD_W-1:0]      res_card_reg, res_card_next;
    logic                   res_failed_reg, res_failed_next;
    logic                   res_done_reg, res_done_next;

    logic                   out_valid_reg;
    logic [CARD_W-1:0]      out_card_reg;
    logic                   out_failed_reg;
    logic                   out_empty_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_done_reg;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [CARD_W-1:0]      ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [CARD_W-1:0]      ram_rd_data;

    css_div_req_t           div_req;
    css_div_rsp_t           div_rsp;

    logic                   in_fire;
    logic                   out_load;
    logic [ADDR_W-1:0]      shuf_i;
    logic [COUNT_W-1:0]     span;
    logic [DIV_W-1:0]       j_sum;
    logic [COUNT_W-1:0]     cursor_adv;

    css_ram #(
        .WIDTH (CARD_W),
        .DEPTH (STACK_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    css_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_load  = (state_reg == S_RESULT) && (!out_valid_reg || rsp.ready);

    // A cursor left stale by pops restarts the pass at the bottom of the stack.
    assign shuf_i     = (COUNT_W'(cursor_reg) >= count_reg - COUNT_W'(1)) ? '0 : cursor_reg;
    assign span       = count_reg - COUNT_W'(shuf_i);
    assign j_sum      = DIV_W'(cursor_reg) + {1'b0, div_rsp.quotient};
    assign cursor_adv = COUNT_W'(cursor_reg) + COUNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        init_idx_next   = init_idx_reg;
        init_suit_next  = init_suit_reg;
        init_num_next   = init_num_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        j_next          = j_reg;
        tmp_next        = tmp_reg;
        res_card_next   = res_card_reg;
        res_failed_next = res_failed_reg;
        res_done_next   = res_done_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = init_idx_reg;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = cursor_reg;
        div_req         = '0;

        unique case (state_reg)
            S_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = init_idx_reg;
                if (COUNT_W'(init_idx_reg) < COUNT_W'(DECK_CARDS))
                begin
                    ram_wr_data = {init_suit_reg, init_num_reg};
                end
                if (init_num_reg == NUM_W'(NUMBER_COUNT))
                begin
                    init_num_next  = NUM_W'(1);
                    init_suit_next = init_suit_reg + 1'b1;
                end
                else
                begin
                    init_num_next = init_num_reg + 1'b1;
                end
                init_idx_next = init_idx_reg + 1'b1;
                if (init_idx_reg == ADDR_W'(STACK_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_card_next   = '0;
                res_failed_next = 1'b0;
                res_done_next   = 1'b0;
                unique case (kind_reg) inside
                    KIND_PUSH:
                    begin
                        if (count_reg >= COUNT_W'(STACK_SLOTS))
                        begin
                            res_failed_next = 1'b1;
                        end
                        else
                        begin
                            ram_wr_en     = 1'b1;
                            ram_wr_addr   = ADDR_W'(count_reg);
                            ram_wr_data   = card_reg;
                            count_next    = count_reg + 1'b1;
                            res_card_next = card_reg;
                        end
                        state_next = S_RESULT;
                    end
                    KIND_POP, KIND_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_failed_next = 1'b1;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = ADDR_W'(count_reg - COUNT_W'(1));
                            state_next  = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        if (count_reg < COUNT_W'(2))
                        begin
                            cursor_next   = '0;
                            res_done_next = 1'b1;
                            state_next    = S_RESULT;
                        end
                        else
                        begin
                            cursor_next      = shuf_i;
                            div_req.start    = 1'b1;
                            div_req.dividend = RANDOM_FULL_SCALE;
                            div_req.divisor  = DIV_W'(span);
                            state_next       = S_DIV1;
                        end
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                res_card_next = ram_rd_data;
                if (kind_reg == KIND_POP)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                state_next = S_RESULT;
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = rand_reg;
                    div_req.divisor  = {1'b0, div_rsp.quotient} + 1'b1;
                    state_next       = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    if (j_sum >= DIV_W'(count_reg))
                    begin
                        j_next = ADDR_W'(count_reg - COUNT_W'(1));
                    end
                    else
                    begin
                        j_next = ADDR_W'(j_sum);
                    end
                    state_next = S_RD_I;
                end
            end
            S_RD_I:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cursor_reg;
                state_next  = S_RD_J;
            end
            S_RD_J:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = j_reg;
                tmp_next    = ram_rd_data;
                state_next  = S_WR_I;
            end
            S_WR_I:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cursor_reg;
                ram_wr_data = ram_rd_data;
                state_next  = S_WR_J;
            end
            S_WR_J:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = j_reg;
                ram_wr_data = tmp_reg;
                if (cursor_adv >= count_reg - COUNT_W'(1))
                begin
                    cursor_next   = '0;
                    res_done_next = 1'b1;
                end
                else
                begin
                    cursor_next = ADDR_W'(cursor_adv);
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_idx_reg  <= '0;
            init_suit_reg <= '0;
            init_num_reg  <= NUM_W'(1);
            count_reg     <= COUNT_W'(DECK_CARDS);
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            init_suit_reg <= init_suit_next;
            init_num_reg  <= init_num_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= req.kind;
            card_reg <= req.card_in;
            rand_reg <= RANDOM_BITS'(req.random_word);
        end
        j_reg          <= j_next;
        tmp_reg        <= tmp_next;
        res_card_reg   <= res_card_next;
        res_failed_reg <= res_failed_next;
        res_done_reg   <= res_done_next;
        if (out_load)
        begin
            out_card_reg   <= res_card_reg;
            out_failed_reg <= res_failed_reg;
            out_empty_reg  <= (count_reg == '0);
            out_count_reg  <= COUNT_OUT_W'(count_reg);
            out_done_reg   <= res_done_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.card_out     = out_card_reg;
    assign rsp.failed       = out_failed_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.count_out    = out_count_reg;
    assign rsp.shuffle_done = out_done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STACK_SLOTS))
        else $error("Card count exceeds the number of stack slots.");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("Divider finished outside a shuffle division state.");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg != S_IDLE && state_reg != S_RESULT))
        else $error("Card memory written while no transaction is in work.");

    a_done_resets_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && res_done_reg && kind_reg == KIND_SHUFFLE) |-> cursor_reg == '0)
        else $error("Shuffle pass completed without returning the cursor to zero.");

    a_fail_zero_card: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_failed_reg |-> out_card_reg == '0)
        else $error("Failed transaction reported a nonzero card.");

endmodule

`default_nettype wire
